// ===== rtl/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// Dynamic priority scheduler package
// Shared types, codes and defaults for the ready queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam logic signed [7:0] PRIO_MIN = 8'sh80;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REQUEUED  = 3'd2,
    ST_FINISHED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_HEAD,
    ENG_WALK,
    ENG_PUT
  } eng_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        proc_id;
    logic signed [7:0] priority_req;
    logic [7:0]        need_time;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        ran_id;
    logic signed [7:0] ran_priority;
    logic [7:0]        ran_time;
    logic [4:0]        queue_count;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] prio;
    logic [7:0]        need;
    logic [7:0]        rtime;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/dps_engine.sv =====
// ----------------------------------------------------------------------------
// Dynamic priority scheduler engine
// Circular ready queue in a one-port-write, one-port-read memory. Pops read
// the head; inserts walk from the tail toward the head, moving one entry back
// per cycle until the new entry finds its place.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_engine #(
  parameter int unsigned QueueDepth = dps_pkg::QUEUE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  dps_pkg::in_beat_t   req_i,
  output logic                idle_o,
  output logic                done_o,
  output dps_pkg::out_beat_t  res_o
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  dps_pkg::eng_state_e state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       pos_q, pos_d;
  dps_pkg::entry_t     new_q, new_d;
  dps_pkg::out_beat_t  res_q, res_d;

  dps_pkg::entry_t     mem_q [QueueDepth];
  dps_pkg::entry_t     rdata_q;
  logic                wen;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  dps_pkg::entry_t     wdata;

  logic [7:0]          rt_inc;
  logic [CW+4:0]       cnt_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] lpos);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, lpos};
    if (s >= (AW+1)'(QueueDepth)) begin
      s = s - (AW+1)'(QueueDepth);
    end
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dps_pkg::ENG_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    new_q <= new_d;
    res_q <= res_d;
  end

  assign rt_inc = rdata_q.rtime + 8'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dps_pkg::ENG_IDLE: begin
        if (start_i) begin
          if (req_i.kind == dps_pkg::KIND_ADD) begin
            if (count_q != CW'(QueueDepth)) begin
              state_d = (count_q == '0) ? dps_pkg::ENG_PUT : dps_pkg::ENG_WALK;
            end
          end else if (count_q != '0) begin
            state_d = dps_pkg::ENG_HEAD;
          end
        end
      end
      dps_pkg::ENG_HEAD: begin
        if (rt_inc >= rdata_q.need) begin
          state_d = dps_pkg::ENG_IDLE;
        end else if (count_q == CW'(1)) begin
          state_d = dps_pkg::ENG_PUT;
        end else begin
          state_d = dps_pkg::ENG_WALK;
        end
      end
      dps_pkg::ENG_WALK: begin
        if (rdata_q.prio >= new_q.prio) begin
          state_d = dps_pkg::ENG_IDLE;
        end else if (pos_q == AW'(1)) begin
          state_d = dps_pkg::ENG_PUT;
        end
      end
      dps_pkg::ENG_PUT: begin
        state_d = dps_pkg::ENG_IDLE;
      end
      default: state_d = dps_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    new_d   = new_q;
    res_d   = res_q;
    wen     = 1'b0;
    waddr   = phys(head_q, pos_q);
    wdata   = new_q;
    raddr   = head_q;
    done_o  = 1'b0;
    unique case (state_q)
      dps_pkg::ENG_IDLE: begin
        if (start_i) begin
          res_d = '0;
          if (req_i.kind == dps_pkg::KIND_ADD) begin
            if (count_q == CW'(QueueDepth)) begin
              res_d.status = dps_pkg::ST_FULL;
              done_o       = 1'b1;
            end else begin
              res_d.status = dps_pkg::ST_ADDED;
              new_d        = '{id: req_i.proc_id, prio: req_i.priority_req,
                               need: req_i.need_time, rtime: 8'd0};
              pos_d        = count_q[AW-1:0];
              raddr        = phys(head_q, pos_d - AW'(1));
            end
          end else if (count_q == '0) begin
            res_d.status = dps_pkg::ST_EMPTY;
            done_o       = 1'b1;
          end
        end
      end
      dps_pkg::ENG_HEAD: begin
        head_d             = (head_q == AW'(QueueDepth - 1)) ? '0 : head_q + AW'(1);
        count_d            = count_q - CW'(1);
        res_d.ran_id       = rdata_q.id;
        res_d.ran_priority = rdata_q.prio;
        res_d.ran_time     = rt_inc;
        if (rt_inc >= rdata_q.need) begin
          res_d.status = dps_pkg::ST_FINISHED;
          done_o       = 1'b1;
        end else begin
          res_d.status = dps_pkg::ST_REQUEUED;
          new_d        = '{id: rdata_q.id,
                           prio: (rdata_q.prio == dps_pkg::PRIO_MIN) ?
                                 rdata_q.prio : rdata_q.prio - 8'sd1,
                           need: rdata_q.need, rtime: rt_inc};
          pos_d        = count_d[AW-1:0];
          raddr        = phys(head_d, pos_d - AW'(1));
        end
      end
      dps_pkg::ENG_WALK: begin
        wen = 1'b1;
        if (rdata_q.prio >= new_q.prio) begin
          count_d = count_q + CW'(1);
          done_o  = 1'b1;
        end else begin
          wdata = rdata_q;
          pos_d = pos_q - AW'(1);
          raddr = phys(head_q, pos_q - AW'(2));
        end
      end
      dps_pkg::ENG_PUT: begin
        wen     = 1'b1;
        count_d = count_q + CW'(1);
        done_o  = 1'b1;
      end
      default: ;
    endcase
  end

  assign cnt_ext = {5'b0, count_d};

  always_comb begin
    res_o             = res_d;
    res_o.queue_count = cnt_ext[4:0];
  end

  assign idle_o = (state_q == dps_pkg::ENG_IDLE);

endmodule

`default_nettype wire

// ===== rtl/dynamic_priority_scheduler.sv =====
// An add walks the queue from its tail toward its place, and a tick pops the head
// and may reinsert it; full adds and empty ticks finish in the cycle they are
// accepted. The insert walk through the queue memory moves one entry per cycle.
// Results pass the skid register, then the output register; one more item is taken
// while a result waits. Reset empties the queue at once; there is no memory sweep.
// ----------------------------------------------------------------------------
// Dynamic priority scheduler
// Priority-ordered ready queue with add and tick operations and a skid
// register between the engine and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_priority_scheduler #(
  parameter int unsigned QueueDepth = dps_pkg::QUEUE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  dps_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output dps_pkg::out_beat_t  out_data_o
);

  logic               eng_idle;
  logic               eng_done;
  dps_pkg::out_beat_t eng_res;
  logic               start;

  logic               pend_q, pend_d;
  dps_pkg::out_beat_t pend_data_q, pend_data_d;
  logic               out_valid_q, out_valid_d;
  dps_pkg::out_beat_t out_data_q, out_data_d;

  assign in_ready_o = eng_idle && !pend_q;
  assign start      = in_valid_i && in_ready_o;

  dps_engine #(
    .QueueDepth(QueueDepth)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (in_data_i),
    .idle_o (eng_idle),
    .done_o (eng_done),
    .res_o  (eng_res)
  );

  always_comb begin
    pend_d      = pend_q;
    pend_data_d = pend_data_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_data_d  = pend_data_q;
      pend_d      = 1'b0;
    end
    if (eng_done) begin
      pend_d      = 1'b1;
      pend_data_d = eng_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_data_q <= pend_data_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/dynamic_priority_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// Dynamic priority scheduler testbench
// Drives add and tick beats into the ready queue scheduler and compares every
// result beat against a cycle-free model of the sorted queue kept in the
// bench. Covers empty ticks, full-queue rejects, ties, the priority floor and
// zero need times. Random traffic runs with and without idle cycles on both
// channels, and one long receiver hold-off forces the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_priority_scheduler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dps_pkg::*;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_cycles    = 0;
  int        fail_count     = 0;

  entry_t    sched_entries [QUEUE_DEPTH];
  int        sched_count    = 0;
  out_beat_t sched_exp_q [$];

  dynamic_priority_scheduler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic void place_entry(entry_t e);
    int pos;
    pos = 0;
    while (pos < sched_count && $signed(sched_entries[pos].prio) >= $signed(e.prio)) begin
      pos++;
    end
    for (int k = sched_count; k > pos; k--) begin
      sched_entries[k] = sched_entries[k-1];
    end
    sched_entries[pos] = e;
    sched_count++;
  endfunction

  function automatic out_beat_t predict_step(in_beat_t b);
    out_beat_t r;
    entry_t    head;
    r = '0;
    if (b.kind == KIND_ADD) begin
      if (sched_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        head.id    = b.proc_id;
        head.prio  = b.priority_req;
        head.need  = b.need_time;
        head.rtime = 8'd0;
        place_entry(head);
        r.status = ST_ADDED;
      end
    end else if (sched_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      head = sched_entries[0];
      for (int k = 1; k < sched_count; k++) begin
        sched_entries[k-1] = sched_entries[k];
      end
      sched_count--;
      head.rtime     = head.rtime + 8'd1;
      r.ran_id       = head.id;
      r.ran_priority = head.prio;
      r.ran_time     = head.rtime;
      if (head.rtime >= head.need) begin
        r.status = ST_FINISHED;
      end else begin
        if (head.prio != PRIO_MIN) begin
          head.prio = head.prio - 8'sd1;
        end
        place_entry(head);
        r.status = ST_REQUEUED;
      end
    end
    r.queue_count = 5'(sched_count);
    return r;
  endfunction

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    sched_exp_q.push_back(predict_step(b));
  endtask

  task automatic send_add(logic [7:0] id, logic signed [7:0] prio, logic [7:0] need);
    in_beat_t b;
    b.kind         = KIND_ADD;
    b.proc_id      = id;
    b.priority_req = prio;
    b.need_time    = need;
    send_beat(b);
  endtask

  task automatic send_tick();
    in_beat_t b;
    b = '0;
    b.kind = KIND_TICK;
    send_beat(b);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sched_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic in_beat_t random_beat(int add_pct);
    in_beat_t b;
    b.kind    = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_TICK;
    b.proc_id = 8'($urandom);
    case ($urandom_range(3))
      0: b.priority_req = 8'($urandom);
      1: b.priority_req = $urandom_range(1) ? 8'sh7f : PRIO_MIN;
      default: b.priority_req = 8'($urandom_range(4)) - 8'd2;
    endcase
    if ($urandom_range(9) < 8) begin
      b.need_time = 8'($urandom_range(6));
    end else begin
      b.need_time = 8'($urandom);
    end
    return b;
  endfunction

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (sched_exp_q.size() == 0) begin
        $error("unexpected result beat: status %0d id %0d", out_data.status, out_data.ran_id);
        fail_count++;
      end else begin
        want = sched_exp_q.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("ran_id", want.ran_id, out_data.ran_id);
        check_field("ran_priority", $signed(want.ran_priority), $signed(out_data.ran_priority));
        check_field("ran_time", want.ran_time, out_data.ran_time);
        check_field("queue_count", want.queue_count, out_data.queue_count);
      end
    end
  end

  // Ties, the priority floor, a zero need time and the longest need time.
  task automatic test_edge_cases();
    send_tick();
    send_add(8'hff, 8'sh7f, 8'd2);
    send_add(8'haa, 8'sh7f, 8'd1);
    send_add(8'h55, 8'sh81, 8'd255);
    send_add(8'h00, PRIO_MIN, 8'd0);
    repeat (6) send_tick();
    wait_drain();
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_add(8'(i + 1), 8'sd0, 8'd1);
    end
    wait_drain();
  endtask

  // The receiver holds off while the sender keeps offering beats, so the
  // block fills up and drops its ready.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    for (int i = 0; i < 24; i++) begin
      send_beat(random_beat(50));
    end
    wait_drain();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n);
    int add_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_pct        = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 20;
          1: add_pct = 50;
          default: add_pct = 80;
        endcase
      end
      send_beat(random_beat(add_pct));
    end
    wait_drain();
  endtask

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edge_cases();
    test_queue_full();
    test_backpressure();
    test_random_traffic(0, 0, 225);
    test_random_traffic(86, 0, 225);
    test_random_traffic(0, 86, 225);
    test_random_traffic(34, 34, 225);
    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    if (sched_exp_q.size() != 0) begin
      $error("%0d result beats never arrived", sched_exp_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
